// ===== src/wsd_pkg.sv =====
package wsd_pkg;

  // Widest payload length the parser counts; longer extended lengths saturate.
  localparam int unsigned LENGTH_BITS = 64;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

  // Depth of the queue between the header parser and the output stage.
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_BINARY = 3'd1,
    KIND_PING   = 3'd2,
    KIND_PONG   = 3'd3,
    KIND_CLOSE  = 3'd4,
    KIND_OTHER  = 3'd5
  } kind_e;

  // One classified beat handed from the parser to the output stage.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic kind_e kind_of(input logic [3:0] op);
    kind_e k;
    unique case (op)
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      OP_CLOSE:  k = KIND_CLOSE;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== src/wsd_front.sv =====
module wsd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic [7:0]             s_tdata_i,
  output logic                   s_tready_o,
  input  wsd_pkg::fifo_stat_t    stat_i,
  output logic                   push_o,
  output wsd_pkg::item_t         item_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        masked_q, masked_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;

  logic        accept;
  logic [6:0]  len7;
  logic [63:0] len7_sat;
  logic [63:0] ext_acc;
  logic [63:0] ext_sat;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;
  logic        push_c;

  assign s_tready_o = ~stat_i.full;
  assign accept     = s_tvalid_i & s_tready_o;
  assign len7       = s_tdata_i[6:0];
  assign len7_sat   = (64'(len7) > LEN_MAX) ? LEN_MAX : 64'(len7);
  assign ext_acc    = {rem_q[55:0], s_tdata_i};
  assign ext_sat    = (ext_acc > LEN_MAX) ? LEN_MAX : ext_acc;
  assign rem_dec    = (rem_q != 64'd0) ? rem_q - 64'd1 : rem_q;
  assign key_byte   = masked_q ? key_q[{~kidx_q, 3'b000} +: 8] : 8'h00;

  // Next state of the header parser.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    hcnt_d   = hcnt_q;
    rem_d    = rem_q;
    key_d    = key_q;
    kidx_d   = kidx_q;
    if (accept) begin
      unique case (phase_q)
        PH_HDR1: begin
          masked_d = s_tdata_i[7];
          if (len7 == LEN7_EXT16) begin
            phase_d = PH_EXTLEN;
            hcnt_d  = 3'd1;
            rem_d   = 64'd0;
          end else if (len7 == LEN7_EXT64) begin
            phase_d = PH_EXTLEN;
            hcnt_d  = 3'd7;
            rem_d   = 64'd0;
          end else begin
            rem_d = len7_sat;
            if (s_tdata_i[7]) begin
              phase_d = PH_KEY;
              hcnt_d  = 3'd3;
              key_d   = 32'd0;
            end else begin
              kidx_d  = 2'd0;
              phase_d = (len7_sat == 64'd0) ? PH_HDR0 : PH_DATA;
            end
          end
        end
        PH_EXTLEN: begin
          if (hcnt_q == 3'd0) begin
            rem_d = ext_sat;
            if (masked_q) begin
              phase_d = PH_KEY;
              hcnt_d  = 3'd3;
              key_d   = 32'd0;
            end else begin
              kidx_d  = 2'd0;
              phase_d = (ext_sat == 64'd0) ? PH_HDR0 : PH_DATA;
            end
          end else begin
            rem_d  = ext_acc;
            hcnt_d = hcnt_q - 3'd1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], s_tdata_i};
          if (hcnt_q == 3'd0) begin
            kidx_d  = 2'd0;
            phase_d = (rem_q == 64'd0) ? PH_HDR0 : PH_DATA;
          end else begin
            hcnt_d = hcnt_q - 3'd1;
          end
        end
        PH_DATA: begin
          kidx_d = kidx_q + 2'd1;
          rem_d  = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          fin_d    = s_tdata_i[7];
          opcode_d = s_tdata_i[3:0];
          phase_d  = PH_HDR1;
        end
      endcase
    end
  end

  // Beats handed to the output stage: payload bytes and empty-frame ends.
  always_comb begin
    push_c             = 1'b0;
    item_o.data_valid  = 1'b0;
    item_o.raw_byte    = 8'h00;
    item_o.key_byte    = 8'h00;
    item_o.opcode      = opcode_q;
    item_o.fin         = fin_q;
    item_o.last        = 1'b1;
    unique case (phase_q)
      PH_HDR1: begin
        push_c = ~s_tdata_i[7] && (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64)
                 && (len7_sat == 64'd0);
      end
      PH_EXTLEN: begin
        push_c = (hcnt_q == 3'd0) && ~masked_q && (ext_sat == 64'd0);
      end
      PH_KEY: begin
        push_c = (hcnt_q == 3'd0) && (rem_q == 64'd0);
      end
      PH_DATA: begin
        push_c            = 1'b1;
        item_o.data_valid = 1'b1;
        item_o.raw_byte   = s_tdata_i;
        item_o.key_byte   = key_byte;
        item_o.last       = (rem_dec == 64'd0);
      end
      default: begin
        push_c = 1'b0;
      end
    endcase
  end

  assign push_o = accept & push_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= 4'd0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      hcnt_q   <= 3'd0;
      rem_q    <= 64'd0;
      key_q    <= 32'd0;
      kidx_q   <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      hcnt_q   <= hcnt_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

// ===== src/wsd_fifo.sv =====
module wsd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsd_pkg::item_t      item_i,
  input  logic                pop_i,
  output wsd_pkg::item_t      item_o,
  output wsd_pkg::fifo_stat_t stat_o
);
  import wsd_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== src/wsd_back.sv =====
module wsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsd_pkg::item_t      item_i,
  input  logic                item_valid_i,
  output logic                pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [15:0]         m_tdata_o,
  output logic [3:0]          m_tuser_o,
  output logic                m_tlast_o
);
  import wsd_pkg::*;

  logic        vld_q;
  logic        load;
  logic [7:0]  byte_q, byte_d;
  kind_e       kind_q, kind_d;
  logic        dvalid_q, fin_q, last_q, pong_q, close_q;
  logic        pong_d, close_d;

  // The output register refills whenever it is empty or its beat is taken.
  assign load  = item_valid_i & (~vld_q | m_tready_i);
  assign pop_o = load;

  always_comb begin
    kind_d  = kind_of(item_i.opcode);
    byte_d  = item_i.data_valid ? (item_i.raw_byte ^ item_i.key_byte) : 8'h00;
    pong_d  = item_i.last && (kind_d == KIND_PING);
    close_d = item_i.last && (kind_d == KIND_CLOSE);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      kind_q   <= kind_d;
      dvalid_q <= item_i.data_valid;
      fin_q    <= item_i.fin;
      last_q   <= item_i.last;
      pong_q   <= pong_d;
      close_q  <= close_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = {5'b00000, close_q, pong_q, fin_q, byte_q};
  assign m_tuser_o  = {kind_q, dvalid_q};
  assign m_tlast_o  = last_q;

endmodule

// ===== src/websocket_frame_deframer.sv =====
// WebSocket frame deframer.
// The slave stream carries one received byte per beat in s_axis_tdata. Frames
// follow each other with no gap; the parser reads the header (fin and opcode,
// mask bit and 7-bit length, optional 16- or 64-bit extended length, optional
// 4-byte masking key) and gives no beat for any header byte.
// The master stream gives one beat per payload byte, unmasked, with the frame
// kind in tuser and tlast on the last byte. A frame of length zero gives one
// beat with the data flag low and tlast high. A ping or close frame raises the
// pong or close request on its tlast beat.
// Throughput is one byte per cycle: the header parser in the front takes a
// byte every cycle while the two-entry queue has room. A payload beat passes
// from the front through the queue into the output register before it
// appears on the master side, and a stall can hold it in either.
// Reset clears the parser to expect the first header byte and empties the
// queue and output register. When the receiver stalls, the output register
// and then the queue fill, and s_axis_tready drops until a beat is taken.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_final,
                                      // [9] pong_request, [10] close_request
  output logic [3:0]  m_axis_tuser,   // [0] data_valid, [3:1] frame_kind
  output logic        m_axis_tlast    // end_of_frame
);
  import wsd_pkg::*;

  fifo_stat_t stat;
  item_t      push_item;
  item_t      head_item;
  logic       push;
  logic       pop;

  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .push_o     (push),
    .item_o     (push_item)
  );

  wsd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (stat)
  );

  wsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_valid_i (~stat.empty),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser),
    .m_tlast_o    (m_axis_tlast)
  );

  // A beat pushed into the queue is still there, or has moved on, in the cycle after the push.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (!stat.empty || m_axis_tvalid))
    else $error("queued beat lost");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty-frame beat without end of frame");

  a_pong_ping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |->
      (m_axis_tlast && (m_axis_tuser[3:1] == KIND_PING)))
    else $error("pong request outside a ping frame end");

  a_close_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[10]) |->
      (m_axis_tlast && (m_axis_tuser[3:1] == KIND_CLOSE)))
    else $error("close request outside a close frame end");

endmodule
